FILE: design/bitmap_block_allocator_macros.svh
// Assertion helpers for the allocator. Both expect clk and rst_n in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bba_pkg.sv
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 2048;

    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;
    localparam int CMD_W  = 2;
    localparam int BLK_W  = 16;
    localparam int IDX_W  = BLK_W + 1;
    localparam int FDB_W  = 11;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 12;
    localparam int CNT_SAT = (1 << CNT_W) - 1;

    localparam logic [FDB_W-1:0] FDB_RST = FDB_W'(28);

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // result status
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [ST_W-1:0] ST_OOR    = 2'd2;

    // word pointer operations
    localparam logic [2:0] PTR_HOLD  = 3'd0;
    localparam logic [2:0] PTR_START = 3'd1;
    localparam logic [2:0] PTR_BLK   = 3'd2;
    localparam logic [2:0] PTR_ZERO  = 3'd3;
    localparam logic [2:0] PTR_INC   = 3'd4;

    // map write operations
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_SET  = 2'd1;
    localparam logic [1:0] WR_CLR  = 2'd2;
    localparam logic [1:0] WR_ZERO = 2'd3;

    // pending result updates
    localparam logic [2:0] RES_NONE   = 3'd0;
    localparam logic [2:0] RES_ALLOC  = 3'd1;
    localparam logic [2:0] RES_NOFREE = 3'd2;
    localparam logic [2:0] RES_OOR    = 3'd3;
    localparam logic [2:0] RES_OK     = 3'd4;
    localparam logic [2:0] RES_QUERY  = 3'd5;

    typedef struct packed {
        logic       capture;
        logic [2:0] ptr_op;
        logic       rd_en;
        logic [1:0] wr_op;
        logic [2:0] res_op;
        logic       out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             fdb_oor;
        logic             blk_oor;
        logic             found;
        logic             raddr_last;
        logic             ptr_last;
    } ctl_sts_t;

endpackage

FILE: design/bba_ctrl.sv
module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bba_pkg::ctl_sts_t sts,
    output bba_pkg::ctl_cmd_t ctl
);
    import bba_pkg::*;
    `include "bitmap_block_allocator_macros.svh"

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_SCAN0 = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_EVAL  = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        ctl.capture  = 1'b0;
        ctl.ptr_op   = PTR_HOLD;
        ctl.rd_en    = 1'b0;
        ctl.wr_op    = WR_NONE;
        ctl.res_op   = RES_NONE;
        ctl.out_load = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                // clearing sweep after reset, one word per cycle
                ctl.wr_op = WR_ZERO;
                if (sts.ptr_last)
                    state_next = S_IDLE;
                else
                    ctl.ptr_op = PTR_INC;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.cmd)
                    CMD_ALLOC:
                    begin
                        if (sts.fdb_oor)
                        begin
                            ctl.res_op = RES_NOFREE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.ptr_op = PTR_START;
                            state_next = S_SCAN0;
                        end
                    end
                    CMD_FREE, CMD_QUERY:
                    begin
                        if (sts.blk_oor)
                        begin
                            ctl.res_op = RES_OOR;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.ptr_op = PTR_BLK;
                            state_next = S_RD;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ctl.ptr_op = PTR_ZERO;
                        state_next = S_CLR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN0:
            begin
                ctl.rd_en  = 1'b1;
                ctl.ptr_op = PTR_INC;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // evaluate one word while the next one is read
                if (sts.found)
                begin
                    ctl.wr_op  = WR_SET;
                    ctl.res_op = RES_ALLOC;
                    state_next = S_DONE;
                end
                else if (sts.raddr_last)
                begin
                    ctl.res_op = RES_NOFREE;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.ptr_op = PTR_INC;
                end
            end
            S_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.cmd == CMD_FREE)
                begin
                    ctl.wr_op  = WR_CLR;
                    ctl.res_op = RES_OK;
                end
                else
                begin
                    ctl.res_op = RES_QUERY;
                end
                state_next = S_DONE;
            end
            S_CLR:
            begin
                ctl.wr_op = WR_ZERO;
                if (sts.ptr_last)
                begin
                    ctl.res_op = RES_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.ptr_op = PTR_INC;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BBA_ASSERT_NEXT(a_transfer_dispatch, in_valid && in_ready, state_reg == S_DISP, "transfer not dispatched")
    `BBA_ASSERT_NOW(a_scan_is_alloc, state_reg == S_SCAN, sts.cmd == CMD_ALLOC, "scan without allocate")
    `BBA_ASSERT_NEXT(a_done_loads, (state_reg == S_DONE) && (!out_valid_reg || out_ready), out_valid_reg && (state_reg == S_IDLE), "result not presented")

endmodule

FILE: design/bba_dpath.sv
module bba_dpath #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bba_pkg::CMD_W-1:0]  in_cmd,
    input  logic [bba_pkg::BLK_W-1:0]  in_block_index,
    input  logic                       cfg_we,
    input  logic [bba_pkg::FDB_W-1:0]  cfg_fdb,
    input  bba_pkg::ctl_cmd_t          ctl,
    output bba_pkg::ctl_sts_t          sts,
    output logic [bba_pkg::FDB_W-1:0]  alloc_index,
    output logic [bba_pkg::ST_W-1:0]   status,
    output logic                       is_free,
    output logic [bba_pkg::CNT_W-1:0]  free_count
);
    import bba_pkg::*;
    `include "bitmap_block_allocator_macros.svh"

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int TAIL_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
    localparam int CNT_MAX_I = (NUM_BLOCKS < CNT_SAT) ? NUM_BLOCKS : CNT_SAT;

    localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [WORD_W-1:0] TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL_BITS);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(CNT_MAX_I);
    localparam logic [CNT_W-1:0]  CNT_RST   = CNT_W'(NUM_BLOCKS - int'(FDB_RST));
    localparam logic [IDX_W-1:0]  NB        = IDX_W'(NUM_BLOCKS);

    logic [WORD_W-1:0] mem [NUM_WORDS];

    logic [CMD_W-1:0]  cmd_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [FDB_W-1:0]  fdb_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     ptr_next;
    logic [AW-1:0]     raddr_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic [FDB_W-1:0]  res_alloc_reg;
    logic [ST_W-1:0]   res_status_reg;
    logic              res_free_reg;
    logic [FDB_W-1:0]  alloc_index_reg;
    logic [ST_W-1:0]   status_reg;
    logic              is_free_reg;
    logic [CNT_W-1:0]  free_count_reg;

    logic [AW-1:0]     start_word;
    logic [AW-1:0]     blk_word;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] avail;
    logic [WORD_W-1:0] first_oh;
    logic [BIT_W-1:0]  enc;
    logic [IDX_W-1:0]  grant_idx;
    logic [WORD_W-1:0] bit_oh;
    logic              cur_bit;
    logic              wr_en;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;

    assign start_word = AW'(fdb_reg >> BIT_W);
    assign blk_word   = AW'(blk_reg >> BIT_W);

    // search window: not below the first data block, not past the last block
    assign lo_mask  = (raddr_reg == start_word) ? ({WORD_W{1'b1}} << fdb_reg[BIT_W-1:0])
                                                : {WORD_W{1'b1}};
    assign hi_mask  = (raddr_reg == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}};
    assign avail    = ~rdata_reg & lo_mask & hi_mask;
    assign first_oh = avail & (~avail + WORD_W'(1));

    always_comb
    begin
        enc = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (first_oh[i])
                enc = enc | BIT_W'(i);
        end
    end

    assign grant_idx = IDX_W'({raddr_reg, enc});
    assign bit_oh    = WORD_W'(1) << blk_reg[BIT_W-1:0];
    assign cur_bit   = rdata_reg[blk_reg[BIT_W-1:0]];

    assign sts.cmd        = cmd_reg;
    assign sts.fdb_oor    = IDX_W'(fdb_reg) >= NB;
    assign sts.blk_oor    = IDX_W'(blk_reg) >= NB;
    assign sts.found      = |avail;
    assign sts.raddr_last = (raddr_reg == LAST_WORD);
    assign sts.ptr_last   = (ptr_reg == LAST_WORD);

    assign wr_en = (ctl.wr_op != WR_NONE);
    assign waddr = (ctl.wr_op == WR_ZERO) ? ptr_reg : raddr_reg;

    always_comb
    begin
        unique case (ctl.wr_op)
            WR_SET:  wdata = rdata_reg | first_oh;
            WR_CLR:  wdata = rdata_reg & ~bit_oh;
            WR_ZERO: wdata = '0;
            default: wdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= wdata;
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[ptr_reg];
            raddr_reg <= ptr_reg;
        end
    end

    always_comb
    begin
        unique case (ctl.ptr_op)
            PTR_START: ptr_next = start_word;
            PTR_BLK:   ptr_next = blk_word;
            PTR_ZERO:  ptr_next = '0;
            PTR_INC:   ptr_next = (ptr_reg == LAST_WORD) ? ptr_reg : ptr_reg + AW'(1);
            default:   ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.wr_op == WR_SET && cnt_reg != '0)
            cnt_next = cnt_reg - CNT_W'(1);
        else if (ctl.wr_op == WR_CLR && cur_bit && cnt_reg < CNT_MAX)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdb_reg <= FDB_RST;
            cnt_reg <= CNT_RST;
            ptr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                fdb_reg <= cfg_fdb;
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= in_cmd;
            blk_reg <= in_block_index;
        end
        unique case (ctl.res_op)
            RES_ALLOC:
            begin
                res_alloc_reg  <= grant_idx[FDB_W-1:0];
                res_status_reg <= ST_OK;
                res_free_reg   <= 1'b0;
            end
            RES_NOFREE:
            begin
                res_alloc_reg  <= '0;
                res_status_reg <= ST_NOFREE;
                res_free_reg   <= 1'b0;
            end
            RES_OOR:
            begin
                res_alloc_reg  <= '0;
                res_status_reg <= ST_OOR;
                res_free_reg   <= 1'b0;
            end
            RES_OK:
            begin
                res_alloc_reg  <= '0;
                res_status_reg <= ST_OK;
                res_free_reg   <= 1'b0;
            end
            RES_QUERY:
            begin
                res_alloc_reg  <= '0;
                res_status_reg <= ST_OK;
                res_free_reg   <= ~cur_bit;
            end
            default:
            begin
            end
        endcase
        if (ctl.out_load)
        begin
            alloc_index_reg <= res_alloc_reg;
            status_reg      <= res_status_reg;
            is_free_reg     <= res_free_reg;
            free_count_reg  <= cnt_reg;
        end
    end

    assign alloc_index = alloc_index_reg;
    assign status      = status_reg;
    assign is_free     = is_free_reg;
    assign free_count  = free_count_reg;

    `BBA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_MAX, "free counter above limit")
    `BBA_ASSERT_NEXT(a_cnt_dec, ctl.wr_op == WR_SET, (cnt_reg == $past(cnt_reg) - CNT_W'(1)) || ($past(cnt_reg) == '0), "allocate did not take a block")
    `BBA_ASSERT_NEXT(a_cnt_clear, ctl.wr_op == WR_ZERO, $stable(cnt_reg), "clearing changed counter")

endmodule

FILE: design/bitmap_block_allocator.sv
// Bitmap first-fit block allocator: one used bit per block, 64 bits per map word.
// Input channel (in_valid/in_ready) carries cmd and block_index; every transfer
// yields exactly one result on the output channel (out_valid/out_ready) with
// alloc_index, status, is_free and free_count.
// Config channel (cfg_valid/cfg_ready) writes first_data_block; always ready,
// write only while no command is in flight.
// Path from input transfer to out_valid, W = ceil(NUM_BLOCKS/64) map words:
//   allocate: dispatch, then a scan from the first data block word, k = words scanned
//             (up to 32 at 2048 blocks); one map read per cycle sets the pace
//   free, query: read-modify-write of one word
//   clear: all W words zeroed, one word per cycle
//   allocate/free/query that is rejected up front: result set at dispatch
// One command is in flight at a time; the next input transfer is taken in the cycle
// after the previous result is loaded into the output register.
// A result held by a stalled receiver stays in the output register; the next
// command still runs and waits for the register before presenting its result.
// After reset the map is zeroed by a sweep over all W words (32 at 2048 blocks),
// during which in_ready stays low. free_count resets to NUM_BLOCKS - 28.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bba_pkg::CMD_W-1:0]  cmd,
    input  logic [bba_pkg::BLK_W-1:0]  block_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bba_pkg::FDB_W-1:0]  alloc_index,
    output logic [bba_pkg::ST_W-1:0]   status,
    output logic                       is_free,
    output logic [bba_pkg::CNT_W-1:0]  free_count,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bba_pkg::FDB_W-1:0]  first_data_block
);
    import bba_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    bba_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_cmd         (cmd),
        .in_block_index (block_index),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_fdb        (first_data_block),
        .ctl            (ctl),
        .sts            (sts),
        .alloc_index    (alloc_index),
        .status         (status),
        .is_free        (is_free),
        .free_count     (free_count)
    );

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import bba_pkg::*;

    localparam int NBLK     = NUM_BLOCKS_DEF;
    localparam int FREE_MAX = (NBLK < CNT_SAT) ? NBLK : CNT_SAT;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic [BLK_W-1:0] blk;
    } alloc_req_t;

    typedef struct packed {
        logic [FDB_W-1:0] alloc_index;
        logic [ST_W-1:0]  status;
        logic             is_free;
        logic [CNT_W-1:0] free_count;
    } alloc_rsp_t;

    logic             clk              = 1'b0;
    logic             rst_n            = 1'b0;
    logic             in_valid         = 1'b0;
    logic             in_ready;
    logic [CMD_W-1:0] cmd              = '0;
    logic [BLK_W-1:0] block_index      = '0;
    logic             out_valid;
    logic             out_ready        = 1'b0;
    logic [FDB_W-1:0] alloc_index;
    logic [ST_W-1:0]  status;
    logic             is_free;
    logic [CNT_W-1:0] free_count;
    logic             cfg_valid        = 1'b0;
    logic             cfg_ready;
    logic [FDB_W-1:0] first_data_block = '0;

    // shadow of the allocator state
    bit               used_map [NBLK];
    int               free_cnt = NBLK - 28;
    logic [FDB_W-1:0] fdb_cfg  = FDB_RST;

    alloc_req_t  cmd_q[$];
    alloc_rsp_t  pending_rsp_q[$];
    int unsigned issued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int          err_cnt      = 0;

    int          burst_left   = 0;
    int          gap_left     = 0;
    int          rx_mode      = 0;
    int          mode_left    = 0;

    bitmap_block_allocator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .block_index      (block_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .alloc_index      (alloc_index),
        .status           (status),
        .is_free          (is_free),
        .free_count       (free_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .first_data_block (first_data_block)
    );

    always #10 clk = ~clk;

    function automatic alloc_rsp_t apply_command(input logic [CMD_W-1:0] op,
                                                 input logic [BLK_W-1:0] blk);
        alloc_rsp_t r;
        int         i;
        r = '0;
        case (op)
            CMD_ALLOC:
            begin
                r.status = ST_NOFREE;
                for (i = int'(fdb_cfg); i < NBLK; i++)
                begin
                    if (!used_map[i])
                    begin
                        used_map[i] = 1'b1;
                        if (free_cnt > 0)
                            free_cnt--;
                        r.alloc_index = FDB_W'(i);
                        r.status      = ST_OK;
                        break;
                    end
                end
            end
            CMD_FREE:
            begin
                if (blk >= NBLK)
                    r.status = ST_OOR;
                else
                begin
                    if (used_map[blk] && free_cnt < FREE_MAX)
                        free_cnt++;
                    used_map[blk] = 1'b0;
                end
            end
            CMD_QUERY:
            begin
                if (blk >= NBLK)
                    r.status = ST_OOR;
                else
                    r.is_free = !used_map[blk];
            end
            default:
            begin
                // counter is deliberately left alone by clear
                foreach (used_map[j])
                    used_map[j] = 1'b0;
            end
        endcase
        r.free_count = CNT_W'(free_cnt);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < 40)
            $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // prediction and checking, all sampled at the rising edge
    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                fdb_cfg = first_data_block;
            if (out_valid && out_ready)
            begin
                if (pending_rsp_q.size() == 0)
                    report_mismatch("result with nothing pending", 0, 0);
                else
                begin
                    want = pending_rsp_q.pop_front();
                    if (alloc_index !== want.alloc_index)
                        report_mismatch("alloc_index", alloc_index, want.alloc_index);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (is_free !== want.is_free)
                        report_mismatch("is_free", is_free, want.is_free);
                    if (free_count !== want.free_count)
                        report_mismatch("free_count", free_count, want.free_count);
                end
            end
            if (in_valid && in_ready)
            begin
                pending_rsp_q.push_back(apply_command(cmd, block_index));
                accepted_cnt++;
            end
        end
    end

    // command driver: bursts with random gaps
    always @(negedge clk)
    begin
        alloc_req_t req;
        int         r;
        if (rst_n && accepted_cnt == issued_cnt)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                req = cmd_q.pop_front();
                cmd         <= req.op;
                block_index <= req.blk;
                in_valid    <= 1'b1;
                issued_cnt++;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        gap_left = 0;
                    else if (r < 8)
                        gap_left = $urandom_range(1, 5);
                    else
                        gap_left = $urandom_range(6, 30);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: stall pattern changes every so often
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 160);
        end
        else
            mode_left--;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (mode_left % 8) == 0;
            default: out_ready <= (mode_left % 5) != 0;
        endcase
    end

    task automatic add_req(input logic [CMD_W-1:0] op, input int blk);
        alloc_req_t req;
        req.op  = op;
        req.blk = BLK_W'(blk);
        cmd_q.push_back(req);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmd_q.size() != 0 || accepted_cnt != issued_cnt
               || pending_rsp_q.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_first_block(input logic [FDB_W-1:0] v);
        @(negedge clk);
        cfg_valid        <= 1'b1;
        first_data_block <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [FDB_W-1:0] fdb, input int n_items);
        int sent;
        int k;
        int j;
        int r;
        int blk;
        write_first_block(fdb);
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                // a run of allocates, then frees and queries over where they land
                k = $urandom_range(1, 10);
                repeat (k) add_req(CMD_ALLOC, $urandom);
                for (j = 0; j < k; j++)
                    add_req(($urandom_range(0, 2) != 0) ? CMD_FREE : CMD_QUERY,
                            int'(fdb) + $urandom_range(0, 40));
                sent += 2 * k;
            end
            else if (r < 76)
            begin
                add_req(CMD_CLEAR, $urandom);
                sent++;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    blk = $urandom_range(0, NBLK - 1);
                else if (r < 70)
                    blk = $urandom_range(NBLK, 65535);
                else if (r < 85)
                    blk = int'(fdb) + $urandom_range(0, 70);
                else
                begin
                    case ($urandom_range(0, 3))
                        0: blk = 0;
                        1: blk = NBLK - 1;
                        2: blk = NBLK;
                        default: blk = 65535;
                    endcase
                end
                add_req(CMD_W'($urandom), blk);
                sent++;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        int j;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: reserved blocks, range edges, free of unused blocks
        add_req(CMD_QUERY, 0);
        add_req(CMD_QUERY, 27);
        add_req(CMD_QUERY, NBLK - 1);
        add_req(CMD_QUERY, NBLK);
        add_req(CMD_QUERY, 65535);
        add_req(CMD_FREE, 65535);
        add_req(CMD_FREE, NBLK);
        add_req(CMD_FREE, 100);
        add_req(CMD_ALLOC, 65535);
        add_req(CMD_ALLOC, 0);
        add_req(CMD_QUERY, 28);
        add_req(CMD_FREE, 28);
        add_req(CMD_ALLOC, 0);
        add_req(CMD_FREE, NBLK - 1);
        add_req(CMD_CLEAR, 65535);
        add_req(CMD_QUERY, 29);
        add_req(CMD_FREE, 29);
        wait_idle();

        // only the top block is searchable: grant, then nothing free
        write_first_block(FDB_W'(NBLK - 1));
        add_req(CMD_ALLOC, 0);
        add_req(CMD_ALLOC, 0);
        add_req(CMD_QUERY, NBLK - 1);
        add_req(CMD_FREE, NBLK - 1);
        add_req(CMD_ALLOC, 0);
        wait_idle();

        // block zero granted, told apart from failure only by status
        write_first_block('0);
        add_req(CMD_ALLOC, 0);
        add_req(CMD_FREE, 0);
        add_req(CMD_ALLOC, 0);
        add_req(CMD_CLEAR, 0);
        wait_idle();

        // fill the searchable top of the map, then allocates fail on it
        write_first_block(FDB_W'(NBLK - 200));
        for (j = 0; j < 208; j++)
        begin
            add_req(CMD_ALLOC, $urandom);
            if (j % 64 == 63)
                add_req(CMD_QUERY, $urandom_range(NBLK - 200, NBLK - 1));
        end
        repeat (6)
        begin
            add_req(CMD_FREE, $urandom_range(NBLK - 200, NBLK - 1));
            add_req(CMD_ALLOC, $urandom);
        end
        add_req(CMD_CLEAR, $urandom);
        wait_idle();

        random_phase(FDB_RST, 110);
        random_phase(FDB_W'(NBLK - 8), 110);
        random_phase(FDB_W'(NBLK - 1), 100);
        random_phase('0, 110);
        random_phase(FDB_W'($urandom_range(1, NBLK - 2)), 110);
        random_phase(FDB_W'(1024), 110);
        random_phase(FDB_W'($urandom), 110);

        repeat (50) @(posedge clk);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
